FILE: sv/dnle_pkg.sv
`default_nettype none

package dnle_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LabelDepthDef = 32;

  localparam logic [ByteW-1:0] CharDash = 8'h2D;
  localparam logic [ByteW-1:0] CharDot = 8'h2E;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input request is taken this cycle
    logic emit_len;  // load the output register with the label length
    logic emit_chr;  // load the output register with the next buffered character
    logic end_name;  // the current flush is the end-of-name flush
    logic done;      // the current flush finishes this cycle; empty the buffer
  } dnle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dot;     // input byte is a label separator
    logic in_last;    // input byte closes the name
    logic slot_free;  // output register can take a new request this cycle
    logic cnt_zero;   // label buffer is empty
    logic chr_final;  // next character to send is the last one of the label
  } dnle_stat_t;

  // Letters, digits and hyphen are kept in a label.
  function automatic logic keeps_char(input logic [ByteW-1:0] c);
    logic upper;
    logic lower;
    logic digit;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return upper || lower || digit || (c == CharDash);
  endfunction

endpackage

`default_nettype wire

FILE: sv/dnle_datapath.sv
`default_nettype none

module dnle_datapath #(
  parameter int unsigned LABEL_DEPTH = dnle_pkg::LabelDepthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [dnle_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                      in_last_i,
  input  wire dnle_pkg::dnle_cmd_t       cmd_i,
  output dnle_pkg::dnle_stat_t           stat_o,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic [dnle_pkg::ByteW-1:0]     out_byte_o,
  output logic                           out_is_len_o,
  output logic                           out_ovf_o,
  output logic                           out_last_o
);
  import dnle_pkg::*;

  localparam int unsigned CntW = $clog2(LABEL_DEPTH + 1);
  localparam int unsigned IdxW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(LABEL_DEPTH);

  logic [ByteW-1:0] store_q [LABEL_DEPTH];
  logic [ByteW-1:0] rdata_q;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            ovf_q, ovf_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_is_len_q, out_is_len_d;
  logic             out_ovf_q, out_ovf_d;
  logic             out_last_q, out_last_d;

  logic keep;
  logic has_room;
  logic wr_en;

  assign keep     = keeps_char(in_byte_i);
  assign has_room = count_q < DepthC;
  assign wr_en    = cmd_i.accept && keep && has_room;

  assign stat_o.is_dot    = in_byte_i == CharDot;
  assign stat_o.in_last   = in_last_i;
  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.cnt_zero  = count_q == '0;
  assign stat_o.chr_final = (idx_q + CntW'(1)) == count_q;

  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_is_len_d = out_is_len_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.accept && keep) begin
      if (has_room) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    // The overflow flag travels with each result, so a later input cannot
    // change a result that is still waiting in the output register.
    if (cmd_i.emit_len) begin
      out_valid_d  = 1'b1;
      out_byte_d   = ByteW'(count_q);
      out_is_len_d = 1'b1;
      out_ovf_d    = ovf_q;
      out_last_d   = cmd_i.end_name && stat_o.cnt_zero;
      idx_d        = '0;
    end else if (cmd_i.emit_chr) begin
      out_valid_d  = 1'b1;
      out_byte_d   = rdata_q;
      out_is_len_d = 1'b0;
      out_ovf_d    = ovf_q;
      out_last_d   = cmd_i.end_name && stat_o.chr_final;
      idx_d        = idx_q + CntW'(1);
    end

    if (cmd_i.done) begin
      count_d = '0;
    end
  end

  // Label buffer: one write port from the input side, one registered read
  // port that always fetches the entry the flush will send next.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q[IdxW-1:0]] <= in_byte_i;
    end
    rdata_q <= store_q[idx_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_is_len_q <= out_is_len_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_is_len_o = out_is_len_q;
  assign out_ovf_o    = out_ovf_q;
  assign out_last_o   = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("label count beyond buffer depth");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_len && cmd_i.emit_chr))
    else $error("two results loaded in one cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_len || cmd_i.emit_chr) |-> stat_o.slot_free)
    else $error("result loaded over one not yet taken");

  a_accept_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !(cmd_i.emit_len || cmd_i.emit_chr || cmd_i.done))
    else $error("input taken during a flush");

endmodule

`default_nettype wire

FILE: sv/dnle_ctrl.sv
`default_nettype none

module dnle_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dnle_pkg::dnle_stat_t stat_i,
  output dnle_pkg::dnle_cmd_t       cmd_o
);
  import dnle_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_CHR
  } state_e;

  state_e state_q, state_d;
  logic   end_q, end_d;    // flush in progress closes the name
  logic   pend_q, pend_d;  // an end-of-name flush follows the current one

  always_comb begin
    state_d = state_q;
    end_d   = end_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.end_name = end_q;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (stat_i.is_dot) begin
            state_d = S_LEN;
            end_d   = 1'b0;
            pend_d  = stat_i.in_last;
          end else if (stat_i.in_last) begin
            state_d = S_LEN;
            end_d   = 1'b1;
            pend_d  = 1'b0;
          end
        end
      end
      S_LEN: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_len = 1'b1;
          if (stat_i.cnt_zero) begin
            cmd_o.done = 1'b1;
            if (pend_q) begin
              end_d  = 1'b1;
              pend_d = 1'b0;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_CHR;
          end
        end
      end
      S_CHR: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_chr = 1'b1;
          if (stat_i.chr_final) begin
            cmd_o.done = 1'b1;
            if (pend_q) begin
              state_d = S_LEN;
              end_d   = 1'b1;
              pend_d  = 1'b0;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      end_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      pend_q  <= pend_d;
    end
  end

  a_pend_only_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !end_q)
    else $error("second flush pending during end-of-name flush");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending flush lost on return to idle");

  a_done_exits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.done && !pend_q) |=> (state_q == S_IDLE))
    else $error("flush finished but controller did not return to idle");

endmodule

`default_nettype wire

FILE: sv/dotted_name_label_encoder.sv
// Dotted-name label encoder.
// The input stream carries a dotted name one character per request on
// s_axis (tdata = character, tlast = final character of the name). The
// output stream on m_axis carries the label encoding: for every label a
// length request (tuser = 1) followed by the label's characters
// (tuser = 0). tdata bit 8 reports the sticky overflow flag, set once a
// label held more than LABEL_DEPTH characters and the extra ones were
// dropped. tlast marks the final byte of the end-of-name flush.
// A character that is neither a dot nor the end of the name, kept or
// dropped, is taken and the block stays ready for the next one. A dot or
// the end of the name starts a flush: the controller sends the length
// byte and then the label's n characters, read one at a time through the
// single read port of the label buffer; a dot marked last adds a
// zero-length label.
// The output register parts the two sides; while the receiver stalls, the
// flush simply waits and s_axis_tready stays low until it completes.
// Reset clears the state machine, the label count and the overflow flag;
// the buffer contents need no clearing.
`default_nettype none

module dotted_name_label_encoder #(
  parameter int unsigned LABEL_DEPTH = dnle_pkg::LabelDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] overflowed, [15:9] zero
  output logic             m_axis_tuser,   // is_length
  output logic             m_axis_tlast    // out_last
);
  import dnle_pkg::*;

  dnle_cmd_t  cmd;
  dnle_stat_t stat;

  logic [ByteW-1:0] out_byte;
  logic             out_ovf;

  dnle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dnle_datapath #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (out_byte),
    .out_is_len_o (m_axis_tuser),
    .out_ovf_o    (out_ovf),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_ovf, out_byte};

endmodule

`default_nettype wire
